// File: rtl/tsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_pkg
// Shared types and constants of the scratchpad-to-millidegrees converter.
// ----------------------------------------------------------------------------
package tsm_pkg;

	localparam int IN_W      = 8;   // width of each scratchpad byte
	localparam int OUT_W     = 22;  // signed millidegrees
	localparam int PROD_W    = 26;  // signed reading times 1000
	localparam int NUM_W     = 18;  // magnitude of the half-degree numerator
	localparam int FMT_W     = 2;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [FMT_W-1:0] FMT_UNKNOWN   = 2'd0;
	localparam logic [FMT_W-1:0] FMT_HALF      = 2'd1;
	localparam logic [FMT_W-1:0] FMT_SIXTEENTH = 2'd2;

	// Register word index of sensor_format.
	localparam logic REG_FORMAT = 1'b0;

	typedef enum logic [1:0] {
		KIND_ZERO      = 2'd0,
		KIND_HALF      = 2'd1,
		KIND_SIXTEENTH = 2'd2
	} kind_t;

	// One classified reading as it waits between front and back.
	typedef struct packed {
		kind_t                    kind;
		logic signed [PROD_W-1:0] prod;  // reading or half-degree base, times 1000
		logic                     neg;   // numerator of the correction is negative
		logic [NUM_W-1:0]         num;   // |per_degree - remain| * 1000
		logic [IN_W-1:0]          div;   // count per degree
	} entry_t;

	// One stage of the restoring divider pipeline.
	typedef struct packed {
		kind_t                    kind;
		logic signed [PROD_W-1:0] prod;
		logic                     neg;
		logic [IN_W-1:0]          div;
		logic [NUM_W-1:0]         sh;    // numerator bits out at the top, quotient in below
		logic [IN_W-1:0]          rem;
	} div_stage_t;

endpackage

// File: rtl/tsm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_front
// Classifies a scratchpad reading by format and prepares the operands.
// ----------------------------------------------------------------------------
module tsm_front (
	input  logic [tsm_pkg::FMT_W-1:0] fmt,
	input  logic [tsm_pkg::IN_W-1:0]  temp_low,
	input  logic [tsm_pkg::IN_W-1:0]  temp_high,
	input  logic [tsm_pkg::IN_W-1:0]  count_remain,
	input  logic [tsm_pkg::IN_W-1:0]  count_per_degree,
	output tsm_pkg::entry_t           entry
);
	import tsm_pkg::*;

	logic [IN_W:0]             diff;
	logic [IN_W:0]             mag;
	logic [IN_W:0]             neg_n;
	logic [IN_W:0]             half_mag;
	logic signed [15:0]        op;
	logic signed [PROD_W-1:0]  op_ext;

	always_comb begin
		diff  = {1'b0, count_per_degree} - {1'b0, count_remain};
		mag   = diff[IN_W] ? (~diff + 9'd1) : diff;
		// A negative half-degree reading is floor(-(256 - low) / 2).
		neg_n    = 9'd256 - {1'b0, temp_low};
		half_mag = (neg_n + 9'd1) >> 1;

		if (fmt == FMT_SIXTEENTH) begin
			op = $signed({temp_high, temp_low});
		end else if (temp_high == '0) begin
			op = $signed({9'd0, temp_low[IN_W-1:1]});
		end else begin
			op = $signed(16'd0 - {7'd0, half_mag});
		end
		op_ext = PROD_W'(op);

		entry.prod = op_ext * 26'sd1000;
		entry.neg  = diff[IN_W];
		entry.num  = NUM_W'(mag) * 18'd1000;
		entry.div  = count_per_degree;

		if (fmt == FMT_SIXTEENTH) begin
			entry.kind = KIND_SIXTEENTH;
		end else if (fmt == FMT_HALF && count_per_degree != '0) begin
			entry.kind = KIND_HALF;
		end else begin
			entry.kind = KIND_ZERO;
		end
	end

endmodule

// File: rtl/tsm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_queue
// Short first-in first-out queue of classified readings.
// ----------------------------------------------------------------------------
module tsm_queue #(
	parameter int DEPTH = tsm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tsm_pkg::entry_t wr_entry,
	input  logic            pop,
	output tsm_pkg::entry_t rd_entry,
	output logic            full,
	output logic            empty
);
	import tsm_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_not_full_and_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(full && empty)) else $error("queue both full and empty");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("queue count did not follow a push");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from an empty queue");

endmodule

// File: rtl/tsm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_back
// Pipelined restoring divider for the half-degree correction, final
// rounding of the sixteenth-degree product, and the output register.
// ----------------------------------------------------------------------------
module tsm_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tsm_pkg::entry_t           head,
	input  logic                      empty,
	output logic                      pop,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [23:0]               m_tdata   // [21:0] millidegrees, [23:22] zero
);
	import tsm_pkg::*;

	div_stage_t                  pipe_q [NUM_W+1];
	logic [NUM_W:0]              vld_q;
	logic                        out_valid_q;
	logic signed [OUT_W-1:0]     out_data_q;
	logic                        adv;
	logic signed [OUT_W-1:0]     result;
	logic signed [OUT_W-1:0]     quot;
	logic signed [PROD_W-1:0]    rounded;

	// One quotient bit per stage.
	function automatic div_stage_t div_step(input div_stage_t a);
		div_stage_t    b;
		logic [IN_W:0] trial;
		logic [IN_W:0] sub;
		b     = a;
		trial = {a.rem, a.sh[NUM_W-1]};
		sub   = trial - {1'b0, a.div};
		if (trial >= {1'b0, a.div}) begin
			b.rem = sub[IN_W-1:0];
			b.sh  = {a.sh[NUM_W-2:0], 1'b1};
		end else begin
			b.rem = trial[IN_W-1:0];
			b.sh  = {a.sh[NUM_W-2:0], 1'b0};
		end
		return b;
	endfunction

	assign adv = !out_valid_q || m_tready;
	assign pop = adv && !empty;

	always_ff @(posedge clk) begin
		if (adv) begin
			pipe_q[0].kind <= head.kind;
			pipe_q[0].prod <= head.prod;
			pipe_q[0].neg  <= head.neg;
			pipe_q[0].div  <= head.div;
			pipe_q[0].sh   <= head.num;
			pipe_q[0].rem  <= '0;
			for (int k = 1; k <= NUM_W; k++) begin
				pipe_q[k] <= div_step(pipe_q[k-1]);
			end
			out_data_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q       <= {vld_q[NUM_W-1:0], pop};
			out_valid_q <= vld_q[NUM_W];
		end
	end

	always_comb begin
		quot    = pipe_q[NUM_W].neg ? -$signed({4'd0, pipe_q[NUM_W].sh})
		                            : $signed({4'd0, pipe_q[NUM_W].sh});
		// Truncation toward zero of a division by sixteen.
		rounded = pipe_q[NUM_W].prod + (pipe_q[NUM_W].prod[PROD_W-1] ? 26'sd15 : 26'sd0);
		case (pipe_q[NUM_W].kind)
			KIND_HALF:      result = $signed(pipe_q[NUM_W].prod[OUT_W-1:0]) - 22'sd250 + quot;
			KIND_SIXTEENTH: result = $signed(rounded[PROD_W-1:4]);
			default:        result = '0;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_data_q};

	a_pop_enters: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> vld_q[0]) else $error("popped reading did not enter the divider");

	a_last_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_q[NUM_W] |=> out_valid_q)
		else $error("finished reading lost before the output register");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |=> out_valid_q && $stable(out_data_q))
		else $error("stalled result changed");

endmodule

// File: rtl/thermometer_scratchpad_to_millidegrees.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermometer_scratchpad_to_millidegrees
// Converts thermometer scratchpad bytes to signed millidegrees Celsius.
// ----------------------------------------------------------------------------
// Input beats arrive on s_tvalid/s_tready/s_tdata, one scratchpad reading per
// beat; each gives exactly one result beat on m_tvalid/m_tready/m_tdata.
// The format register (byte address 0 of the APB port) picks the rule:
// 0 unknown (result 0), 1 half-degree with counts, 2 sixteenth-degree.
// It resets to sixteenth-degree and should be written only while idle.
// A front stage classifies each reading and forms the operands; a four-entry
// queue lets the front keep accepting while the back stalls. The back runs an
// 18-stage restoring divider, one quotient bit per stage, then an output
// register. One beat is accepted per cycle while the queue is not full; a reading
// passes the queue, the divider input register, its stages and the output register.
// When the receiver holds m_tready low, the divider and output freeze and the
// queue fills; s_tready falls once the queue is full.
// Reset clears the queue, the pipeline valid bits and the output valid bit.
// ----------------------------------------------------------------------------
module thermometer_scratchpad_to_millidegrees #(
	parameter int QUEUE_DEPTH = tsm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// [7:0] temp_low, [15:8] temp_high, [23:16] count_remain, [31:24] count_per_degree
	input  logic [31:0]                 s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [21:0] millidegrees, [23:22] zero
	output logic [23:0]                 m_tdata,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tsm_pkg::ADDR_W-1:0]  paddr,
	input  logic [tsm_pkg::DATA_W-1:0]  pwdata,
	output logic [tsm_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import tsm_pkg::*;

	logic [FMT_W-1:0] fmt_q;
	entry_t           front_entry;
	entry_t           head;
	logic             push;
	logic             pop;
	logic             full;
	logic             empty;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FORMAT) ? {{(DATA_W-FMT_W){1'b0}}, fmt_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_SIXTEENTH;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_FORMAT) begin
			fmt_q <= pwdata[FMT_W-1:0];
		end
	end

	assign s_tready = !full;
	assign push     = s_tvalid && s_tready;

	tsm_front u_front (
		.fmt              (fmt_q),
		.temp_low         (s_tdata[7:0]),
		.temp_high        (s_tdata[15:8]),
		.count_remain     (s_tdata[23:16]),
		.count_per_degree (s_tdata[31:24]),
		.entry            (front_entry)
	);

	tsm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (front_entry),
		.pop      (pop),
		.rd_entry (head),
		.full     (full),
		.empty    (empty)
	);

	tsm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
